@@ hw/rtl/rme_pkg.sv @@
package rme_pkg;

  // Datapath and instruction field sizes
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned RegCount   = 4;
  localparam int unsigned RegIdxW    = $clog2(RegCount);
  localparam int unsigned ImmWidth   = 16;
  localparam int unsigned FuncWidth  = 4;
  localparam int unsigned OpCount    = 16;
  localparam int unsigned MapWidth   = OpCount * FuncWidth;
  localparam int unsigned QueueDepth = 2;

  // Identity remap of encoded opcodes
  localparam logic [MapWidth-1:0] MapReset = 64'hFEDC_BA98_7654_3210;

  typedef enum logic [FuncWidth-1:0] {
    OP_ADDR = 4'd0,
    OP_ADDI = 4'd1,
    OP_MULR = 4'd2,
    OP_MULI = 4'd3,
    OP_BANR = 4'd4,
    OP_BANI = 4'd5,
    OP_BORR = 4'd6,
    OP_BORI = 4'd7,
    OP_SETR = 4'd8,
    OP_SETI = 4'd9,
    OP_GTIR = 4'd10,
    OP_GTRI = 4'd11,
    OP_GTRR = 4'd12,
    OP_EQIR = 4'd13,
    OP_EQRI = 4'd14,
    OP_EQRR = 4'd15
  } op_e;

  // Decoded instruction passed from front to back
  typedef struct packed {
    op_e                 op;
    logic [ImmWidth-1:0] opa;
    logic [ImmWidth-1:0] opb;
    logic [RegIdxW-1:0]  dest;
  } instr_t;

endpackage

@@ hw/rtl/rme_front.sv @@
module rme_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rme_pkg::MapWidth-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rme_pkg::FuncWidth-1:0]    func_i,
  input  logic [rme_pkg::ImmWidth-1:0]     operand_a_i,
  input  logic [rme_pkg::ImmWidth-1:0]     operand_b_i,
  input  logic [rme_pkg::RegIdxW-1:0]      dest_reg_i,
  output logic                             push_valid_o,
  input  logic                             push_ready_i,
  output rme_pkg::instr_t                  push_instr_o
);

  logic [rme_pkg::MapWidth-1:0] map_q, map_d;

  // Take a map write on every config transfer
  assign cfg_ready_o = 1'b1;

  always_comb begin
    map_d = map_q;
    if (cfg_valid_i) begin
      map_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= rme_pkg::MapReset;
    end else begin
      map_q <= map_d;
    end
  end

  // Remap the encoded opcode and hand the instruction to the queue
  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

  always_comb begin
    push_instr_o.op   = rme_pkg::op_e'(map_q[func_i * rme_pkg::FuncWidth +: rme_pkg::FuncWidth]);
    push_instr_o.opa  = operand_a_i;
    push_instr_o.opb  = operand_b_i;
    push_instr_o.dest = dest_reg_i;
  end

endmodule

@@ hw/rtl/rme_queue.sv @@
module rme_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  rme_pkg::instr_t push_instr_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output rme_pkg::instr_t pop_instr_o
);

  localparam int unsigned PtrW = (rme_pkg::QueueDepth > 1) ? $clog2(rme_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(rme_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(rme_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(rme_pkg::QueueDepth);

  rme_pkg::instr_t entries_q [rme_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntFull);
  assign pop_valid_o  = (count_q != '0);
  assign pop_instr_o  = entries_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_instr_i;
    end
  end

endmodule

@@ hw/rtl/rme_back.sv @@
module rme_back (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   pop_valid_i,
  output logic                                                   pop_ready_o,
  input  rme_pkg::instr_t                                        pop_instr_i,
  output logic                                                   out_valid_o,
  input  logic                                                   out_ready_i,
  output logic [rme_pkg::RegCount-1:0][rme_pkg::DataWidth-1:0]   regs_o
);

  logic [rme_pkg::RegCount-1:0][rme_pkg::DataWidth-1:0] regs_q, regs_d;
  logic [rme_pkg::RegCount-1:0][rme_pkg::DataWidth-1:0] out_regs_q;
  logic                                                 out_valid_q, out_valid_d;
  logic                                                 exec;
  logic [rme_pkg::DataWidth-1:0]                        ra, rb, ia, ib, res;
  logic [rme_pkg::DataWidth-1:0]                        mul_b;

  // Execute when the output stage is free or drains this cycle
  assign exec        = pop_valid_i && (!out_valid_q || out_ready_i);
  assign pop_ready_o = exec;

  // Operand fetch and zero-extended immediates
  assign ra = regs_q[pop_instr_i.opa[rme_pkg::RegIdxW-1:0]];
  assign rb = regs_q[pop_instr_i.opb[rme_pkg::RegIdxW-1:0]];
  assign ia = rme_pkg::DataWidth'(pop_instr_i.opa);
  assign ib = rme_pkg::DataWidth'(pop_instr_i.opb);

  assign mul_b = (pop_instr_i.op == rme_pkg::OP_MULR) ? rb : ib;

  // ALU: wrap arithmetic, signed compares give one or zero
  always_comb begin
    res = '0;
    case (pop_instr_i.op)
      rme_pkg::OP_ADDR: res = ra + rb;
      rme_pkg::OP_ADDI: res = ra + ib;
      rme_pkg::OP_MULR,
      rme_pkg::OP_MULI: res = ra * mul_b;
      rme_pkg::OP_BANR: res = ra & rb;
      rme_pkg::OP_BANI: res = ra & ib;
      rme_pkg::OP_BORR: res = ra | rb;
      rme_pkg::OP_BORI: res = ra | ib;
      rme_pkg::OP_SETR: res = ra;
      rme_pkg::OP_SETI: res = ia;
      rme_pkg::OP_GTIR: res = rme_pkg::DataWidth'($signed(ia) > $signed(rb));
      rme_pkg::OP_GTRI: res = rme_pkg::DataWidth'($signed(ra) > $signed(ib));
      rme_pkg::OP_GTRR: res = rme_pkg::DataWidth'($signed(ra) > $signed(rb));
      rme_pkg::OP_EQIR: res = rme_pkg::DataWidth'(ia == rb);
      rme_pkg::OP_EQRI: res = rme_pkg::DataWidth'(ra == ib);
      rme_pkg::OP_EQRR: res = rme_pkg::DataWidth'(ra == rb);
      default:          res = '0;
    endcase
  end

  // Write back the result and snapshot the file into the output stage
  always_comb begin
    regs_d      = regs_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (exec) begin
      regs_d[pop_instr_i.dest] = res;
      out_valid_d              = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      regs_q      <= regs_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result until the output transfer
  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_regs_q <= regs_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign regs_o      = out_regs_q;

endmodule

@@ hw/rtl/register_machine_executor.sv @@
// From input transfer to output transfer the instruction is written into the queue,
// then executed from the queue head, which registers the result in the output stage.
// Throughput: one instruction per cycle unless out_ready_i stalls the output stage,
// set by the back-end ALU and write-back; a two-entry queue decouples front and back.
// Reset (asynchronous, active low) clears all registers, empties the queue,
// drops the output stage and loads the identity opcode map.
module register_machine_executor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rme_pkg::MapWidth-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rme_pkg::FuncWidth-1:0]       func_i,
  input  logic [rme_pkg::ImmWidth-1:0]        operand_a_i,
  input  logic [rme_pkg::ImmWidth-1:0]        operand_b_i,
  input  logic [rme_pkg::RegIdxW-1:0]         dest_reg_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [31:0]                  reg0_value_o,
  output logic signed [31:0]                  reg1_value_o,
  output logic signed [31:0]                  reg2_value_o,
  output logic signed [31:0]                  reg3_value_o
);

  logic                                                 push_valid, push_ready;
  logic                                                 pop_valid, pop_ready;
  rme_pkg::instr_t                                      push_instr, pop_instr;
  logic [rme_pkg::RegCount-1:0][rme_pkg::DataWidth-1:0] regs;

  rme_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .dest_reg_i   (dest_reg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_instr_o (push_instr)
  );

  rme_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_instr_i (push_instr),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_instr_o  (pop_instr)
  );

  rme_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_instr_i (pop_instr),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .regs_o      (regs)
  );

  // Present the register file snapshot on the result ports
  assign reg0_value_o = $signed(regs[0]);
  assign reg1_value_o = $signed(regs[1]);
  assign reg2_value_o = $signed(regs[2]);
  assign reg3_value_o = $signed(regs[3]);

endmodule
